// File: rtl/sliding_window_spread_counter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window spread counter
// Each macro expands to a concurrent assertion in simulation and to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SPREAD_COUNTER_ASSERT_SVH
`define SLIDING_WINDOW_SPREAD_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SWSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define SWSC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SWSC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SWSC_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/swsc_pkg.sv
// ----------------------------------------------------------------------------
// swsc_pkg
// Shared constants, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swsc_pkg;

   localparam int DEFAULT_WINDOW_DEPTH = 1024;
   localparam int DEFAULT_SAMPLE_WIDTH = 32;
   localparam int LIMIT_W              = 32;
   localparam int COUNT_W              = 48;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DROP,
      ST_XFER_RD,
      ST_XFER_WR,
      ST_POP,
      ST_POP_WAIT,
      ST_PUSH,
      ST_EVAL,
      ST_CHECK,
      ST_FINISH
   } swsc_state_type;

   typedef struct packed {
      logic load;      // take the item in, clear on a first marker
      logic set_clip;  // oldest sample dropped because the window is full
      logic xfer_rd;   // pop the back stack, read its value
      logic xfer_wr;   // push the value read onto the front stack
      logic pop;       // pop the front stack, read the entry below
      logic pop_load;  // load the new front top from the read data
      logic push;      // push the sample onto the back stack
      logic finish;    // update the count and load the result register
   } swsc_cmd_type;

   typedef struct packed {
      logic out_free;
      logic front_empty;
      logic back_empty;
      logic window_full;
      logic window_multi;
      logic spread_over;
   } swsc_status_type;

endpackage

// File: rtl/swsc_ram.sv
// ----------------------------------------------------------------------------
// swsc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/swsc_datapath.sv
// ----------------------------------------------------------------------------
// swsc_datapath
// Two stacks with running minimum and maximum, spread register, saturating
// segment count and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swsc_datapath #(
   parameter int WINDOW_DEPTH = 1024,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample,
   input  logic                                  req_first,
   input  logic                                  csr_wr_en,
   input  logic [swsc_pkg::LIMIT_W-1:0]          csr_wr_data,
   input  logic                                  rsp_stall,
   input  swsc_pkg::swsc_cmd_type                cmd,
   output swsc_pkg::swsc_status_type             sts,
   output logic                                  rsp_valid,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0]     rsp_window_length,
   output logic [swsc_pkg::COUNT_W-1:0]          rsp_segment_count,
   output logic                                  rsp_window_clipped
);

   import swsc_pkg::*;

   localparam int SW    = SAMPLE_WIDTH;
   localparam int AW    = $clog2(WINDOW_DEPTH);
   localparam int CW    = $clog2(WINDOW_DEPTH + 1);
   localparam int DW    = SW + 1;
   localparam int CMP_W = (DW > LIMIT_W) ? DW : LIMIT_W;

   logic signed [SW-1:0]  sample_ff, sample_in;
   logic                  clip_ff, clip_in;
   logic [CW-1:0]         front_count_ff, front_count_in;
   logic [CW-1:0]         back_count_ff, back_count_in;
   logic signed [SW-1:0]  front_min_ff, front_min_in, front_max_ff, front_max_in;
   logic signed [SW-1:0]  back_min_ff, back_min_in, back_max_ff, back_max_in;
   logic [DW-1:0]         spread_ff, spread_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [COUNT_W-1:0]    total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]         rsp_len_ff, rsp_len_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_clip_ff, rsp_clip_in;

   logic [SW-1:0]         back_rd_data;
   logic [2*SW-1:0]       front_rd_data;
   logic signed [SW-1:0]  xfer_val;
   logic signed [SW-1:0]  fmin_new, fmax_new, bmin_new, bmax_new;
   logic signed [SW-1:0]  win_min, win_max;
   logic [CW-1:0]         window_len, back_top_idx, front_below_idx;
   logic [COUNT_W:0]      total_sum;
   logic [COUNT_W-1:0]    total_sat;

   assign xfer_val        = back_rd_data;
   assign back_top_idx    = back_count_ff - CW'(1);
   assign front_below_idx = front_count_ff - CW'(2);
   assign window_len      = front_count_ff + back_count_ff;

   // Each front stack entry holds the extremes of itself and everything below it.
   always_comb begin
      if (front_count_ff == '0) begin
         fmin_new = xfer_val;
         fmax_new = xfer_val;
      end else begin
         fmin_new = (front_min_ff < xfer_val) ? front_min_ff : xfer_val;
         fmax_new = (front_max_ff > xfer_val) ? front_max_ff : xfer_val;
      end
      if (back_count_ff == '0) begin
         bmin_new = sample_ff;
         bmax_new = sample_ff;
      end else begin
         bmin_new = (back_min_ff < sample_ff) ? back_min_ff : sample_ff;
         bmax_new = (back_max_ff > sample_ff) ? back_max_ff : sample_ff;
      end
   end

   always_comb begin
      if (front_count_ff == '0) begin
         win_min = back_min_ff;
         win_max = back_max_ff;
      end else if (back_count_ff == '0) begin
         win_min = front_min_ff;
         win_max = front_max_ff;
      end else begin
         win_min = (front_min_ff < back_min_ff) ? front_min_ff : back_min_ff;
         win_max = (front_max_ff > back_max_ff) ? front_max_ff : back_max_ff;
      end
      // The maximum is never below the minimum, so the difference fits unsigned.
      spread_in = {win_max[SW-1], win_max} - {win_min[SW-1], win_min};
   end

   assign total_sum = {1'b0, total_ff} + (COUNT_W + 1)'(window_len);
   assign total_sat = total_sum[COUNT_W] ? {COUNT_W{1'b1}} : total_sum[COUNT_W-1:0];

   always_comb begin
      sample_in      = sample_ff;
      clip_in        = clip_ff;
      front_count_in = front_count_ff;
      back_count_in  = back_count_ff;
      front_min_in   = front_min_ff;
      front_max_in   = front_max_ff;
      back_min_in    = back_min_ff;
      back_max_in    = back_max_ff;
      limit_in       = limit_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_clip_in    = rsp_clip_ff;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end
      if (cmd.load) begin
         sample_in = req_sample;
         clip_in   = 1'b0;
         if (req_first) begin
            front_count_in = '0;
            back_count_in  = '0;
            total_in       = '0;
         end
      end
      if (cmd.set_clip) begin
         clip_in = 1'b1;
      end
      if (cmd.xfer_rd) begin
         back_count_in = back_top_idx;
      end
      if (cmd.xfer_wr) begin
         front_count_in = front_count_ff + CW'(1);
         front_min_in   = fmin_new;
         front_max_in   = fmax_new;
      end
      if (cmd.pop) begin
         front_count_in = front_count_ff - CW'(1);
      end
      if (cmd.pop_load && front_count_ff != '0) begin
         front_min_in = front_rd_data[2*SW-1:SW];
         front_max_in = front_rd_data[SW-1:0];
      end
      if (cmd.push) begin
         back_count_in = back_count_ff + CW'(1);
         back_min_in   = bmin_new;
         back_max_in   = bmax_new;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         total_in     = total_sat;
         rsp_valid_in = 1'b1;
         rsp_len_in   = window_len;
         rsp_count_in = total_sat;
         rsp_clip_in  = clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_count_ff <= '0;
         back_count_ff  <= '0;
         limit_ff       <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         front_count_ff <= front_count_in;
         back_count_ff  <= back_count_in;
         limit_ff       <= limit_in;
         total_ff       <= total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      clip_ff      <= clip_in;
      front_min_ff <= front_min_in;
      front_max_ff <= front_max_in;
      back_min_ff  <= back_min_in;
      back_max_ff  <= back_max_in;
      spread_ff    <= spread_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_count_ff <= rsp_count_in;
      rsp_clip_ff  <= rsp_clip_in;
   end

   // Back stack entry: the sample value only. The back stack only ever empties
   // as a whole, so the extremes of its top are all it needs, kept in registers.
   swsc_ram #(
      .WIDTH (SW),
      .DEPTH (WINDOW_DEPTH)
   ) u_back_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (back_count_ff[AW-1:0]),
      .wr_data (sample_ff),
      .rd_en   (cmd.xfer_rd),
      .rd_addr (back_top_idx[AW-1:0]),
      .rd_data (back_rd_data)
   );

   // Front stack entry: running minimum, running maximum.
   swsc_ram #(
      .WIDTH (2 * SW),
      .DEPTH (WINDOW_DEPTH)
   ) u_front_ram (
      .clock   (clock),
      .wr_en   (cmd.xfer_wr),
      .wr_addr (front_count_ff[AW-1:0]),
      .wr_data ({fmin_new, fmax_new}),
      .rd_en   (cmd.pop),
      .rd_addr (front_below_idx[AW-1:0]),
      .rd_data (front_rd_data)
   );

   assign sts.out_free     = !rsp_valid_ff || !rsp_stall;
   assign sts.front_empty  = (front_count_ff == '0);
   assign sts.back_empty   = (back_count_ff == '0);
   assign sts.window_full  = (window_len == CW'(WINDOW_DEPTH));
   assign sts.window_multi = (window_len > CW'(1));
   assign sts.spread_over  = (CMP_W'(spread_ff) > CMP_W'(limit_ff));

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window_length  = rsp_len_ff;
   assign rsp_segment_count  = rsp_count_ff;
   assign rsp_window_clipped = rsp_clip_ff;

endmodule

// File: rtl/swsc_ctrl.sv
// ----------------------------------------------------------------------------
// swsc_ctrl
// Sequencer: accept, clip, push, trim loop with stack transfers, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swsc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  swsc_pkg::swsc_status_type  sts,
   output swsc_pkg::swsc_cmd_type     cmd
);

   import swsc_pkg::*;

   swsc_state_type state_ff, state_in;
   // Set once the sample is pushed: a removal then returns to the spread check.
   logic           trim_ff, trim_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         trim_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         trim_ff  <= trim_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      trim_in  = trim_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               trim_in  = 1'b0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (sts.window_full) begin
               cmd.set_clip = 1'b1;
               state_in     = ST_DROP;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_DROP: begin
            state_in = sts.front_empty ? ST_XFER_RD : ST_POP;
         end
         ST_XFER_RD: begin
            cmd.xfer_rd = 1'b1;
            state_in    = ST_XFER_WR;
         end
         ST_XFER_WR: begin
            cmd.xfer_wr = 1'b1;
            state_in    = sts.back_empty ? ST_POP : ST_XFER_RD;
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_POP_WAIT;
         end
         ST_POP_WAIT: begin
            cmd.pop_load = 1'b1;
            state_in     = trim_ff ? ST_EVAL : ST_PUSH;
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            trim_in  = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // The spread register catches up with the stack tops here.
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.window_multi && sts.spread_over) begin
               state_in = ST_DROP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: rtl/sliding_window_spread_counter.sv
// ----------------------------------------------------------------------------
// sliding_window_spread_counter
// Takes one signed sample per item and keeps the longest window of recent
// samples whose maximum minus minimum stays within csr_wr_data's last value;
// each item returns the window length, the saturating running sum of lengths,
// and a flag when the oldest sample fell out because WINDOW_DEPTH was reached.
// The window is a queue of two stacks in RAM; front entries carry running
// extremes, the back stack keeps those of its top in registers. One item at
// a time: an item with no removal passes the accept, full-window check, push,
// spread register, compare and result steps. A removal for spread adds drop,
// pop, pop wait, spread register and compare; a drop of the oldest sample from
// a full window adds drop, pop and pop wait. An empty front stack is refilled
// from the back stack, each sample a RAM read followed by a RAM write. The result
// register lets the next item enter while a result still waits on rsp_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_spread_counter_assert.svh"

module sliding_window_spread_counter #(
   parameter int WINDOW_DEPTH = swsc_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int SAMPLE_WIDTH = swsc_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_sample,
   input  logic                              req_first,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0] rsp_window_length,
   output logic [swsc_pkg::COUNT_W-1:0]      rsp_segment_count,
   output logic                              rsp_window_clipped,
   input  logic                              csr_wr_en,
   input  logic [swsc_pkg::LIMIT_W-1:0]      csr_wr_data
);

   import swsc_pkg::*;

   localparam int CW = $clog2(WINDOW_DEPTH + 1);

   swsc_cmd_type    cmd;
   swsc_status_type sts;

   swsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   swsc_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_sample         (req_sample),
      .req_first          (req_first),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_stall          (rsp_stall),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_window_length  (rsp_window_length),
      .rsp_segment_count  (rsp_segment_count),
      .rsp_window_clipped (rsp_window_clipped)
   );

   `SWSC_ASSERT_NXT(a_busy_after_accept, clock, reset,
      req_valid && !req_stall, req_stall,
      "item accepted but block not busy next cycle")
   `SWSC_ASSERT_IMP(a_len_range, clock, reset, rsp_valid,
      (rsp_window_length != '0) && (rsp_window_length <= CW'(WINDOW_DEPTH)),
      "result window length out of range")
   `SWSC_ASSERT_IMP(a_pop_nonempty, clock, reset, cmd.pop, !sts.front_empty,
      "front stack popped while empty")
   `SWSC_ASSERT_IMP(a_push_room, clock, reset, cmd.push, !sts.window_full,
      "sample pushed into a full window")

endmodule

// File: dv/tb_sliding_window_spread_counter.sv
// ----------------------------------------------------------------------------
// Testbench for sliding_window_spread_counter
// Streams signed samples through the block and predicts every result with
// a two-stack window model of its own: window length, saturating segment
// count and the full-window drop flag are compared field by field. Runs
// directed extremes, a full-window drop test and random sample streams under
// several spread limits and idle patterns on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_window_spread_counter;

   import swsc_pkg::*;

   localparam int DEPTH    = DEFAULT_WINDOW_DEPTH;
   localparam int SAMPLE_W = DEFAULT_SAMPLE_WIDTH;
   localparam int LEN_W    = $clog2(DEPTH + 1);
   localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};
   localparam logic [LIMIT_W-1:0] LIMIT_TOP = {LIMIT_W{1'b1}};

   typedef struct packed {
      logic [LEN_W-1:0]   window_length;
      logic [COUNT_W-1:0] segment_count;
      logic               window_clipped;
   } window_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [SAMPLE_W-1:0]        req_sample = '0;
   logic                              req_first = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [LEN_W-1:0]                  rsp_window_length;
   logic [COUNT_W-1:0]                rsp_segment_count;
   logic                              rsp_window_clipped;
   logic                              csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]                csr_wr_data = '0;

   int send_idle_pct = 28;
   int recv_idle_pct = 72;
   int fail_count    = 0;

   window_result_type expected_results[$];

   // Window model: back stack with values and extremes, front stack with extremes only.
   logic signed [SAMPLE_W-1:0] back_val[DEPTH];
   logic signed [SAMPLE_W-1:0] back_lo[DEPTH];
   logic signed [SAMPLE_W-1:0] back_hi[DEPTH];
   logic signed [SAMPLE_W-1:0] front_lo[DEPTH];
   logic signed [SAMPLE_W-1:0] front_hi[DEPTH];
   int                         back_n    = 0;
   int                         front_n   = 0;
   logic [COUNT_W-1:0]         seg_total = '0;
   logic [LIMIT_W-1:0]         spread_limit = '0;

   sliding_window_spread_counter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_first          (req_first),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_window_length  (rsp_window_length),
      .rsp_segment_count  (rsp_segment_count),
      .rsp_window_clipped (rsp_window_clipped),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Removes the oldest sample; an empty front stack is refilled from the back.
   function automatic void drop_oldest();
      logic signed [SAMPLE_W-1:0] x;
      if (front_n == 0) begin
         while (back_n > 0) begin
            back_n--;
            x = back_val[back_n];
            front_lo[front_n] = (front_n == 0 || x < front_lo[front_n-1]) ?
                                x : front_lo[front_n-1];
            front_hi[front_n] = (front_n == 0 || x > front_hi[front_n-1]) ?
                                x : front_hi[front_n-1];
            front_n++;
         end
      end
      if (front_n > 0) front_n--;
   endfunction

   function automatic window_result_type predict_window(logic signed [SAMPLE_W-1:0] x,
                                                         logic first_mark);
      window_result_type  r;
      logic signed [SAMPLE_W-1:0] lo, hi;
      longint             spread;
      logic [COUNT_W-1:0] len;
      bit                 settled;
      r = '0;
      if (first_mark) begin
         back_n    = 0;
         front_n   = 0;
         seg_total = '0;
      end
      if (front_n + back_n >= DEPTH) begin
         drop_oldest();
         r.window_clipped = 1'b1;
      end
      back_val[back_n] = x;
      back_lo[back_n]  = (back_n == 0 || x < back_lo[back_n-1]) ? x : back_lo[back_n-1];
      back_hi[back_n]  = (back_n == 0 || x > back_hi[back_n-1]) ? x : back_hi[back_n-1];
      back_n++;
      settled = 0;
      while (!settled) begin
         if (front_n + back_n <= 1) begin
            settled = 1;
         end else begin
            if (front_n == 0) begin
               lo = back_lo[back_n-1];
               hi = back_hi[back_n-1];
            end else if (back_n == 0) begin
               lo = front_lo[front_n-1];
               hi = front_hi[front_n-1];
            end else begin
               lo = (front_lo[front_n-1] < back_lo[back_n-1]) ?
                    front_lo[front_n-1] : back_lo[back_n-1];
               hi = (front_hi[front_n-1] > back_hi[back_n-1]) ?
                    front_hi[front_n-1] : back_hi[back_n-1];
            end
            spread = longint'(hi) - longint'(lo);
            if (spread <= longint'(spread_limit)) settled = 1;
            else drop_oldest();
         end
      end
      len = COUNT_W'(front_n + back_n);
      if (seg_total > COUNT_TOP - len) seg_total = COUNT_TOP;
      else seg_total = seg_total + len;
      r.window_length = LEN_W'(front_n + back_n);
      r.segment_count = seg_total;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch in %s: expected %0d, got %0d", field, want, got);
   endtask

   always @(posedge clock) begin : result_checker
      window_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("result with no item pending: length %0d count %0d clipped %0b",
                        rsp_window_length, rsp_segment_count, rsp_window_clipped);
         end else begin
            want = expected_results.pop_front();
            if (rsp_window_length !== want.window_length)
               report_mismatch("window_length", want.window_length, rsp_window_length);
            if (rsp_segment_count !== want.segment_count)
               report_mismatch("segment_count", want.segment_count, rsp_segment_count);
            if (rsp_window_clipped !== want.window_clipped)
               report_mismatch("window_clipped", want.window_clipped, rsp_window_clipped);
         end
      end
   end

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic first_mark);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      req_first  <= first_mark;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.insert(expected_results.size(), predict_window(value, first_mark));
   endtask

   // The limit only changes while no item is in flight.
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      spread_limit = value;
   endtask

   task automatic test_directed_cases();
      write_limit('0);
      send_sample(32'sd0, 1'b1);
      send_sample(32'sd0, 1'b0);
      send_sample(32'sd0, 1'b0);
      // A large step forces the queue back down to the lone new sample.
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sd1, 1'b0);
      // At the top limit even the widest possible spread fits.
      write_limit(LIMIT_TOP);
      send_sample(32'h7FFF_FFFF, 1'b1);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'sd0, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      write_limit(LIMIT_TOP - 1);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h7FFF_FFFE, 1'b0);
      send_sample(32'h8000_0001, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      write_limit(32'd1);
      send_sample(32'sd5, 1'b1);
      send_sample(32'sd6, 1'b0);
      send_sample(32'sd5, 1'b0);
      send_sample(32'sd7, 1'b0);
      send_sample(32'sd6, 1'b0);
      send_sample(32'sd6, 1'b0);
   endtask

   // With the top limit nothing is removed for spread, so the window fills.
   task automatic test_window_clip();
      write_limit(LIMIT_TOP);
      send_sample($urandom, 1'b1);
      repeat (DEPTH + 40) send_sample($urandom, 1'b0);
   endtask

   task automatic send_streams(input int n_items);
      int                         sent;
      int                         run_len;
      int                         kind;
      bit                         walk;
      longint                     amp;
      longint                     delta;
      longint unsigned            r;
      logic signed [SAMPLE_W-1:0] base, cur;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_sample($urandom, ($urandom_range(0, 3) == 0));
            sent++;
         end else begin
            // Short runs stand for broken sequences.
            run_len = (kind == 1) ? $urandom_range(1, 4) : $urandom_range(8, 80);
            if (run_len > n_items - sent) run_len = n_items - sent;
            case ($urandom_range(0, 3))
               0: amp = $urandom_range(0, 3);
               1: amp = longint'(spread_limit) / 4 + 1;
               2: amp = longint'(spread_limit) + 1;
               default: amp = longint'($urandom);
            endcase
            walk = $urandom_range(0, 1);
            base = $urandom;
            cur  = base;
            for (int i = 0; i < run_len; i++) begin
               send_sample(cur, i == 0);
               sent++;
               r     = {$urandom, $urandom};
               delta = longint'(r % longint'(2 * amp + 1)) - amp;
               cur   = (walk ? cur : base) + SAMPLE_W'(delta);
            end
         end
      end
   endtask

   task automatic test_random_streams(input int send_pct, input int recv_pct,
                                      input int n_items);
      logic [LIMIT_W-1:0] limit_pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (4) begin
         case ($urandom_range(0, 4))
            0: limit_pick = '0;
            1: limit_pick = $urandom_range(1, 64);
            2: limit_pick = $urandom_range(0, 1 << 20);
            3: limit_pick = LIMIT_TOP;
            default: limit_pick = $urandom;
         endcase
         write_limit(limit_pick);
         send_streams(n_items / 4);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_window_clip();
      test_random_streams(28, 72, 256);
      test_random_streams(72, 28, 256);
      test_random_streams(0, 0, 256);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
